[hdl/pdm_pkg.sv]
// ----------------------------------------------------------------------------
// pdm_pkg: shared types and constants for the particle drift map
// Fixed-point formats, transaction payload structures and the saturation
// helper used by the drift pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pdm_pkg;

    // Word format: signed, W bits, F fraction bits.
    localparam int W      = 48;
    localparam int F      = 32;
    localparam int RPP_W  = 35;
    localparam int RVV_W  = 37;
    // Operands above 32 bits are split at this bit into partial products.
    localparam int SPLIT  = 24;
    // Wide product / accumulator width.
    localparam int P_W    = 98;
    // Quotient bits and the shift that lines the dividend up with them.
    localparam int Q_W    = W - 1;
    localparam int SH     = Q_W - F;
    localparam int T_W    = 64;
    localparam int DZ_W   = W + 1;

    // Partial product widths.
    localparam int PR_LO_W = SPLIT + 1 + RPP_W + 1;
    localparam int PR_HI_W = W - SPLIT + RPP_W + 1;
    localparam int PL_LO_W = SPLIT + 1 + W;
    localparam int PL_HI_W = W - SPLIT + W;
    localparam int PD_HI_W = DZ_W - SPLIT + W;

    localparam logic signed [P_W-1:0] P_HALF = {{(P_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [P_W-1:0] P_ONE  = {{(P_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [P_W-1:0] P_MAX  = {{(P_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [P_W-1:0] P_MIN  = {{(P_W-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic        [W-1:0]   W_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [DZ_W-1:0] DZ_ONE = {{(DZ_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};

    typedef struct packed {
        logic signed [W-1:0]     pos_x;
        logic signed [W-1:0]     pos_y;
        logic signed [W-1:0]     mom_x;
        logic signed [W-1:0]     mom_y;
        logic        [RPP_W-1:0] mom_ratio;
        logic        [RVV_W-1:0] vel_ratio;
        logic signed [W-1:0]     path_s;
        logic signed [W-1:0]     long_zeta;
        logic                    last_in;
    } t_in;

    typedef struct packed {
        logic signed [W-1:0] new_x;
        logic signed [W-1:0] new_y;
        logic signed [W-1:0] new_s;
        logic signed [W-1:0] upd_zeta;
        logic                last_out;
    } t_out;

    // Clamp a wide signed value to the word range.
    function automatic logic signed [W-1:0] sat_w(input logic signed [P_W-1:0] v);
        logic signed [W-1:0] r;
        if (v > P_MAX) begin
            r = P_MAX[W-1:0];
        end else if (v < P_MIN) begin
            r = P_MIN[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/particle_drift_map.sv]
// ----------------------------------------------------------------------------
// particle_drift_map: drift map for one tracked particle per transaction
// Slopes, position and path updates, and the longitudinal correction with a
// pipelined restoring divider, all in saturating fixed point.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  input    | in        | i_valid / o_stall  | i_data (t_in)
//  output   | out       | o_valid / i_stall  | o_data (t_out)
//  config   | in        | i_cfg_we           | i_cfg_data (drift length)
//
//  One particle enters per cycle while no held result stalls the pipeline.
//  There are seven arithmetic stages, 47 divider stages (one quotient bit
//  each) and five closing stages; most of them lie in the divider chain.
//  Reset is synchronous and clears the valid bits and the drift length.
//  A stall on the output while a result is held freezes the whole pipeline; nothing is lost.
`default_nettype none

module particle_drift_map (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire pdm_pkg::t_in          i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output pdm_pkg::t_out              o_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [pdm_pkg::W-1:0] i_cfg_data
);
    import pdm_pkg::*;

    typedef struct packed {
        logic signed [W-1:0]     x;
        logic signed [W-1:0]     y;
        logic signed [W-1:0]     ns;
        logic signed [W-1:0]     zeta;
        logic        [RVV_W-1:0] rvv;
        logic                    last;
    } t_side;

    logic signed [W-1:0] r_len;
    logic                en;

    // Stage valid bits, A to L.
    logic r_v_a, r_v_b, r_v_c, r_v_d, r_v_e, r_v_f, r_v_h, r_v_i, r_v_j, r_v_k, r_v_l;
    logic r_dv_v [0:Q_W];

    t_side r_sd_a, r_sd_b, r_sd_c, r_sd_d, r_sd_e, r_sd_f, r_sd_h, r_sd_i, r_sd_j, r_sd_k;
    t_side r_dv_sd [0:Q_W];

    logic signed [PR_LO_W-1:0] r_pxl, r_pyl;
    logic signed [PR_HI_W-1:0] r_pxh, r_pyh;
    logic signed [W-1:0]       r_xp, r_yp;
    logic signed [PL_LO_W-1:0] r_xll, r_yll, r_xxl, r_yyl;
    logic signed [PL_HI_W-1:0] r_xlh, r_ylh, r_xxh, r_yyh;
    logic signed [P_W-1:0]     r_pxlen, r_pylen, r_xx, r_yy;
    logic signed [P_W-1:0]     r_rx, r_ry, r_sum2;
    logic        [T_W-1:0]     r_t;

    logic [RVV_W-1:0] r_dv_rem [0:Q_W];
    logic [Q_W-1:0]   r_dv_q   [0:Q_W];
    logic [SH-1:0]    r_dv_tl  [0:Q_W];
    logic             r_dv_ovf [0:Q_W];

    logic signed [DZ_W-1:0]    r_dz;
    logic signed [PL_LO_W-1:0] r_dl;
    logic signed [PD_HI_W-1:0] r_dh;
    logic signed [P_W-1:0]     r_pz, r_rz;
    t_out                      r_out;

    logic signed [P_W-1:0] n_pxr, n_pyr;
    logic [W-1:0]          n_u;

    // The pipeline moves unless a finished result is held by the receiver.
    assign en      = !(r_v_l && i_stall);
    assign o_stall = !en;
    assign o_valid = r_v_l;
    assign o_data  = r_out;

    // Drift length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    // Valid bits of the arithmetic and closing stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0; r_v_b <= 1'b0; r_v_c <= 1'b0; r_v_d <= 1'b0;
            r_v_e <= 1'b0; r_v_f <= 1'b0; r_dv_v[0] <= 1'b0;
            r_v_h <= 1'b0; r_v_i <= 1'b0; r_v_j <= 1'b0; r_v_k <= 1'b0;
            r_v_l <= 1'b0;
        end else if (en) begin
            r_v_a <= i_valid; r_v_b <= r_v_a; r_v_c <= r_v_b; r_v_d <= r_v_c;
            r_v_e <= r_v_d; r_v_f <= r_v_e; r_dv_v[0] <= r_v_f;
            r_v_h <= r_dv_v[Q_W]; r_v_i <= r_v_h; r_v_j <= r_v_i; r_v_k <= r_v_j;
            r_v_l <= r_v_k;
        end
    end

    // Rounded slopes from the combined partial products, and the clamped quotient.
    always_comb begin
        n_pxr = ((P_W'(r_pxh) <<< SPLIT) + P_W'(r_pxl) + P_HALF) >>> F;
        n_pyr = ((P_W'(r_pyh) <<< SPLIT) + P_W'(r_pyl) + P_HALF) >>> F;
        n_u   = r_dv_ovf[Q_W] ? W_MAX : {1'b0, r_dv_q[Q_W]};
    end

    // Stages A to G: slopes, position products, square sum and divider setup.
    always_ff @(posedge i_clk) begin
        if (en) begin
            // A: capture and slope partial products.
            r_pxl  <= $signed({1'b0, i_data.mom_x[SPLIT-1:0]})
                      * $signed({1'b0, i_data.mom_ratio});
            r_pxh  <= $signed(i_data.mom_x[W-1:SPLIT]) * $signed({1'b0, i_data.mom_ratio});
            r_pyl  <= $signed({1'b0, i_data.mom_y[SPLIT-1:0]})
                      * $signed({1'b0, i_data.mom_ratio});
            r_pyh  <= $signed(i_data.mom_y[W-1:SPLIT]) * $signed({1'b0, i_data.mom_ratio});
            r_sd_a.x    <= i_data.pos_x;
            r_sd_a.y    <= i_data.pos_y;
            r_sd_a.ns   <= sat_w(P_W'(i_data.path_s) + P_W'(r_len));
            r_sd_a.zeta <= i_data.long_zeta;
            r_sd_a.rvv  <= i_data.vel_ratio;
            r_sd_a.last <= i_data.last_in;
            // B: saturated slopes.
            r_xp   <= sat_w(n_pxr);
            r_yp   <= sat_w(n_pyr);
            r_sd_b <= r_sd_a;
            // C: partial products of the drift offsets and the squares.
            r_xll  <= $signed({1'b0, r_xp[SPLIT-1:0]}) * r_len;
            r_xlh  <= $signed(r_xp[W-1:SPLIT]) * r_len;
            r_yll  <= $signed({1'b0, r_yp[SPLIT-1:0]}) * r_len;
            r_ylh  <= $signed(r_yp[W-1:SPLIT]) * r_len;
            r_xxl  <= $signed({1'b0, r_xp[SPLIT-1:0]}) * r_xp;
            r_xxh  <= $signed(r_xp[W-1:SPLIT]) * r_xp;
            r_yyl  <= $signed({1'b0, r_yp[SPLIT-1:0]}) * r_yp;
            r_yyh  <= $signed(r_yp[W-1:SPLIT]) * r_yp;
            r_sd_c <= r_sd_b;
            // D: full products.
            r_pxlen <= (P_W'(r_xlh) <<< SPLIT) + P_W'(r_xll);
            r_pylen <= (P_W'(r_ylh) <<< SPLIT) + P_W'(r_yll);
            r_xx    <= (P_W'(r_xxh) <<< SPLIT) + P_W'(r_xxl);
            r_yy    <= (P_W'(r_yyh) <<< SPLIT) + P_W'(r_yyl);
            r_sd_d  <= r_sd_c;
            // E: rounded offsets and the square sum with its rounding term.
            r_rx   <= (r_pxlen + P_HALF) >>> F;
            r_ry   <= (r_pylen + P_HALF) >>> F;
            r_sum2 <= r_xx + r_yy + P_ONE;
            r_sd_e <= r_sd_d;
            // F: new positions and the divider numerator t = 1 + half square sum.
            r_sd_f.x    <= sat_w(P_W'(r_sd_e.x) + r_rx);
            r_sd_f.y    <= sat_w(P_W'(r_sd_e.y) + r_ry);
            r_sd_f.ns   <= r_sd_e.ns;
            r_sd_f.zeta <= r_sd_e.zeta;
            r_sd_f.rvv  <= r_sd_e.rvv;
            r_sd_f.last <= r_sd_e.last;
            r_t         <= T_W'((r_sum2 >>> (F + 1)) + P_ONE);
            // G: quotient overflow check and the starting remainder.
            r_dv_ovf[0] <= (r_t >> SH) >= T_W'(r_sd_f.rvv);
            r_dv_rem[0] <= r_t[SH +: RVV_W];
            r_dv_tl[0]  <= r_t[SH-1:0];
            r_dv_q[0]   <= '0;
            r_dv_sd[0]  <= r_sd_f;
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar k = 1; k <= Q_W; k++) begin : g_div
        localparam int J = Q_W - k;
        logic           w_bit;
        logic [RVV_W:0] w_rem2;
        logic [RVV_W:0] w_dvs;
        logic           w_ge;

        if (J >= F) begin : g_num
            assign w_bit = r_dv_tl[k-1][J-F];
        end else begin : g_zero
            assign w_bit = 1'b0;
        end

        assign w_rem2 = {r_dv_rem[k-1], w_bit};
        assign w_dvs  = {1'b0, r_dv_sd[k-1].rvv};
        assign w_ge   = w_rem2 >= w_dvs;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (en) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[k] <= w_ge ? RVV_W'(w_rem2 - w_dvs) : RVV_W'(w_rem2);
                r_dv_q[k]   <= {r_dv_q[k-1][Q_W-2:0], w_ge};
                r_dv_tl[k]  <= r_dv_tl[k-1];
                r_dv_ovf[k] <= r_dv_ovf[k-1];
                r_dv_sd[k]  <= r_dv_sd[k-1];
            end
        end
    end

    // Stages H to L: zeta correction and the output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            // H: correction factor dz = 1 - u.
            r_dz   <= DZ_ONE - $signed({1'b0, n_u});
            r_sd_h <= r_dv_sd[Q_W];
            // I: partial products of L * dz.
            r_dl   <= $signed({1'b0, r_dz[SPLIT-1:0]}) * r_len;
            r_dh   <= $signed(r_dz[DZ_W-1:SPLIT]) * r_len;
            r_sd_i <= r_sd_h;
            // J: full product.
            r_pz   <= (P_W'(r_dh) <<< SPLIT) + P_W'(r_dl);
            r_sd_j <= r_sd_i;
            // K: rounding.
            r_rz   <= (r_pz + P_HALF) >>> F;
            r_sd_k <= r_sd_j;
            // L: output transaction.
            r_out.new_x    <= r_sd_k.x;
            r_out.new_y    <= r_sd_k.y;
            r_out.new_s    <= r_sd_k.ns;
            r_out.upd_zeta <= sat_w(P_W'(r_sd_k.zeta) + r_rz);
            r_out.last_out <= r_sd_k.last;
        end
    end

endmodule

`default_nettype wire

[hdl/pdm_checker.sv]
// ----------------------------------------------------------------------------
// pdm_checker: port-level checks for the particle drift map
// Watches the handshakes on the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_stall,
    input wire logic          o_valid,
    input wire logic          i_stall,
    input wire pdm_pkg::t_out o_data
);
    import pdm_pkg::*;

    // A held output transaction stays valid and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output transaction changed while stalled");

    // The input side stalls only while a finished result is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    // With no held output the block always accepts.
    a_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("stall raised with an empty output");

endmodule

bind particle_drift_map pdm_checker u_pdm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the particle drift map
// Streams particles through the drift pipeline with random gaps and output
// stalls, predicts each updated particle in saturating fixed point and checks
// every result against the oldest prediction, showing mismatches by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import pdm_pkg::*;

    localparam int LATENCY    = 59;
    localparam int WDOG_LIMIT = 20000;
    localparam logic signed [W-1:0] WMAX_S = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN_S = {1'b1, {(W-1){1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;
    logic i_cfg_we = 1'b0;
    logic [W-1:0] i_cfg_data = '0;

    // Drift length as the predictor sees it.
    logic signed [W-1:0] drift_len = '0;
    t_out particle_q[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   stall_enable = 1'b1;

    particle_drift_map dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Saturate a wide signed value to the word range.
    function automatic logic signed [W-1:0] clamp_word(input logic signed [127:0] v);
        if (v > 128'(WMAX_S)) return WMAX_S;
        if (v < 128'(WMIN_S)) return WMIN_S;
        return v[W-1:0];
    endfunction

    // Product rounded half up and shifted down by the fraction bits.
    function automatic logic signed [127:0] round_prod(input logic signed [127:0] p);
        return (p + (128'sd1 <<< (F - 1))) >>> F;
    endfunction

    // Predict the drifted particle.
    function automatic t_out drift_particle(input t_in p);
        t_out r;
        logic signed [127:0] len, slope_x, slope_y, half, tsum, quo, dz, one;
        logic [127:0] num;
        len = 128'(drift_len);
        one = 128'sd1 <<< F;
        slope_x = 128'(clamp_word(round_prod(128'(p.mom_x) * $signed({93'd0, p.mom_ratio}))));
        slope_y = 128'(clamp_word(round_prod(128'(p.mom_y) * $signed({93'd0, p.mom_ratio}))));
        r.new_x = clamp_word(128'(p.pos_x) + round_prod(slope_x * len));
        r.new_y = clamp_word(128'(p.pos_y) + round_prod(slope_y * len));
        r.new_s = clamp_word(128'(p.path_s) + len);
        half = (slope_x * slope_x + slope_y * slope_y + one) >>> (F + 1);
        tsum = one + half;
        if (p.vel_ratio == '0) begin
            quo = 128'(WMAX_S);
        end else begin
            num = 128'(tsum) << F;
            quo = $signed(num / {91'd0, p.vel_ratio});
            if (quo > 128'(WMAX_S)) quo = 128'(WMAX_S);
        end
        dz = one - quo;
        r.upd_zeta = clamp_word(128'(p.long_zeta) + round_prod(len * dz));
        r.last_out = p.last_in;
        return r;
    endfunction

    function automatic logic [W-1:0] rand_word();
        return W'({$urandom(), $urandom()});
    endfunction

    // Mostly no idle gap, often a short one, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(9) == 0) return $urandom_range(40, 5);
        if ($urandom_range(2) == 0) return $urandom_range(3, 1);
        return 0;
    endfunction

    // Send one particle and record its prediction on acceptance.
    // Valid stays high after acceptance so that particles can follow back to back.
    task automatic send_particle(input t_in p);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        particle_q.push_back(drift_particle(p));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (particle_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_length(input logic signed [W-1:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        drift_len = v;
    endtask

    // Random particle, ratios mostly in range but sometimes anything.
    function automatic t_in rand_particle();
        t_in p;
        int k;
        p.pos_x = rand_word();
        p.pos_y = rand_word();
        p.path_s = rand_word();
        p.long_zeta = rand_word();
        k = $urandom_range(3);
        // Momenta mostly moderate so saturation does not hide the arithmetic.
        p.mom_x = (k == 0) ? rand_word() : $signed(rand_word()) >>> $urandom_range(30, 8);
        p.mom_y = (k == 0) ? rand_word() : $signed(rand_word()) >>> $urandom_range(30, 8);
        if ($urandom_range(7) == 0) begin
            p.mom_ratio = RPP_W'({$urandom(), $urandom()});
            p.vel_ratio = RVV_W'({$urandom(), $urandom()});
        end else begin
            p.mom_ratio = {3'($urandom_range(3)), $urandom()};
            p.vel_ratio = {5'($urandom_range(15)), $urandom()};
        end
        p.last_in = 1'($urandom_range(1));
        return p;
    endfunction

    // Extremes of every field, zero divisor and out-of-range ratios.
    task automatic test_directed();
        t_in p;
        p = '0;
        p.mom_ratio = 35'd1 << F;
        p.vel_ratio = 37'd1 << F;
        send_particle(p);
        p.pos_x = WMAX_S; p.pos_y = WMIN_S; p.mom_x = WMAX_S; p.mom_y = WMIN_S;
        p.path_s = WMAX_S; p.long_zeta = WMIN_S; p.last_in = 1'b1;
        send_particle(p);
        p.pos_x = WMIN_S; p.pos_y = WMAX_S; p.mom_x = WMIN_S; p.mom_y = WMAX_S;
        p.path_s = WMIN_S; p.long_zeta = WMAX_S; p.last_in = 1'b0;
        send_particle(p);
        p = '0;
        p.vel_ratio = '0;
        p.mom_ratio = '1;
        send_particle(p);
        p.vel_ratio = '1;
        p.mom_ratio = '0;
        send_particle(p);
        p.vel_ratio = 37'd1;
        send_particle(p);
        p.mom_x = 48'sd1 <<< F; p.mom_y = -(48'sd1 <<< F);
        p.mom_ratio = 35'd1 << 30; p.vel_ratio = 37'd1 << 30;
        send_particle(p);
        p.vel_ratio = 37'd1 << 36; p.mom_ratio = 35'd1 << 34;
        send_particle(p);
        repeat (8) send_particle(rand_particle());
    endtask

    task automatic test_random(input int n);
        repeat (n) send_particle(rand_particle());
    endtask

    // Output stall generator and result checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= stall_enable && ($urandom_range(5) == 0 ||
                       (i_stall && $urandom_range(9) != 0 && $urandom_range(3) == 0));
            if (o_valid && !i_stall) begin
                if (particle_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", o_data);
                end else begin
                    t_out e;
                    e = particle_q.pop_front();
                    if (e !== o_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch x %h/%h y %h/%h s %h/%h z %h/%h l %b/%b",
                                e.new_x, o_data.new_x, e.new_y, o_data.new_y,
                                e.new_s, o_data.new_s, e.upd_zeta, o_data.upd_zeta,
                                e.last_out, o_data.last_out);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_length(48'sd3 <<< F);
        test_directed();
        write_length(WMAX_S);
        test_directed();
        write_length(WMIN_S);
        test_directed();
        write_length(-(48'sd1 <<< F));
        test_random(150);
        write_length($signed(rand_word()) >>> 12);
        test_random(150);
        // Sender waits for the pipeline to empty before carrying on.
        wait_drained();
        stall_enable = 1'b0;
        test_random(100);
        stall_enable = 1'b1;
        write_length(rand_word());
        test_random(100);
        write_length(48'sd1 <<< (F - 4));
        test_random(100);
        wait_drained();
        if (mismatches == 0 && particle_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire
